### hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
  localparam int LevelCount = 13;
  localparam int UnitBytes = 64;
  localparam int IdxW = LevelCount - 1;
  localparam int UnitCount = 1 << IdxW;
  localparam int TopLevel = LevelCount - 1;
  localparam int LvlW = 4;
  localparam int PtrW = IdxW + 1;
  localparam int SizeW = 19;
  localparam logic [PtrW-1:0] EmptyMark = PtrW'(UnitCount);
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree = 1'b1;
  localparam logic StatusDone = 1'b0;
  localparam logic StatusOom = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [SizeW-1:0] size_bytes;
    logic [IdxW-1:0]  block_index;
  } req_t;

  typedef struct packed {
    logic            status;
    logic [IdxW-1:0] granted_index;
    logic [LvlW-1:0] granted_level;
  } rsp_t;
endpackage
`default_nettype wire

### hw/rtl/bba_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bba_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hw/rtl/buddy_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// buddy block allocator over 4096 units of 64 bytes, 13 levels
// channels: req (sink) carries mode, size_bytes, block_index; rsp (source)
//   carries status, granted_index, granted_level; valid/ready, taken when both high
// each request item yields exactly one response item
// one item at a time: req ready is high only in idle; the sequencer walks
//   levels and list entries through one next-link memory port (one read or
//   one write per cycle, read data registered)
// sequencing: size to level takes one shift a cycle in S_LEVEL; allocate
//   scans levels in S_SCAN and splits via S_SPLIT_RD, S_SPLIT_WAIT, S_SPLIT_WR;
//   free walks each level's list through S_WALK_RD and S_WALK_WAIT per entry,
//   so it follows the list lengths (bounded by unit count per level)
// reset: level 12 holds block 0, all other lists empty; the next-link memory
//   needs no clearing since the entry for block 0 is written at reset
// a stalled response holds in the output register; the next request is
//   taken once the response is consumed
module buddy_block_allocator_top
  import bba_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  bba_stream_if.sink   req,
  bba_stream_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_LEVEL, S_SCAN, S_SPLIT_RD, S_SPLIT_WAIT, S_SPLIT_WR, S_POP_RD,
    S_POP_WAIT, S_FREE_LVL, S_WALK_RD, S_WALK_WAIT, S_UNLINK_WAIT,
    S_PUSH, S_OUT
  } state_t;

  state_t state;
  logic [PtrW-1:0] heads [LevelCount];
  logic [PtrW-1:0] links [UnitCount];
  logic [PtrW-1:0] rd_data;
  logic            mode;
  logic [SizeW:0]  size;
  logic [SizeW:0]  span;       // shift register for size to level
  logic [LvlW-1:0] lvl;        // requested level
  logic [LvlW-1:0] cur;        // walking level
  logic [IdxW-1:0] addr;
  logic [PtrW-1:0] prev;
  logic [PtrW-1:0] walk;
  logic [PtrW:0]   steps;
  logic [IdxW-1:0] blk;
  logic [IdxW-1:0] buddy;
  rsp_t            out;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.payload = out;
  assign buddy = addr ^ (IdxW'(1) << cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur <= '0;
      for (int i = 0; i < LevelCount; i++) begin
        heads[i] <= EmptyMark;
      end
      heads[TopLevel] <= '0;
      links[0] <= EmptyMark;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode <= req.payload.mode;
            size <= {1'b0, req.payload.size_bytes};
            addr <= req.payload.block_index;
            span <= (SizeW+1)'(UnitBytes);
            lvl <= '0;
            state <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (span < size && lvl < LvlW'(TopLevel)) begin
            span <= span << 1;
            lvl <= lvl + 1'b1;
          end else begin
            cur <= lvl;
            addr <= addr & ~((IdxW'(1) << lvl) - IdxW'(1));
            state <= (mode == ModeAlloc) ? S_SCAN : S_FREE_LVL;
          end
        end
        S_SCAN: begin
          if (heads[cur] < EmptyMark) begin
            state <= (cur == lvl) ? S_POP_RD : S_SPLIT_RD;
          end else if (cur == LvlW'(TopLevel)) begin
            out <= '{status: StatusOom, granted_index: '0, granted_level: '0};
            state <= S_OUT;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        S_SPLIT_RD: begin
          blk <= heads[cur][IdxW-1:0];
          rd_data <= links[heads[cur][IdxW-1:0]];
          state <= S_SPLIT_WAIT;
        end
        S_SPLIT_WAIT: begin
          heads[cur] <= rd_data;
          links[blk + (IdxW'(1) << (cur - 1'b1))] <= EmptyMark;
          state <= S_SPLIT_WR;
        end
        S_SPLIT_WR: begin
          links[blk] <= {1'b0, blk + (IdxW'(1) << (cur - 1'b1))};
          heads[cur - 1'b1] <= {1'b0, blk};
          cur <= cur - 1'b1;
          state <= (cur - 1'b1 == lvl) ? S_POP_RD : S_SPLIT_RD;
        end
        S_POP_RD: begin
          blk <= heads[cur][IdxW-1:0];
          rd_data <= links[heads[cur][IdxW-1:0]];
          state <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          heads[cur] <= rd_data;
          out <= '{status: StatusDone, granted_index: blk, granted_level: cur};
          state <= S_OUT;
        end
        S_FREE_LVL: begin
          if (cur == LvlW'(TopLevel)) begin
            state <= S_PUSH;
          end else begin
            prev <= EmptyMark;
            walk <= heads[cur];
            steps <= '0;
            state <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          if (walk >= EmptyMark || steps > (PtrW+1)'(UnitCount)) begin
            state <= S_PUSH;
          end else if (walk[IdxW-1:0] == buddy) begin
            rd_data <= links[walk[IdxW-1:0]];
            state <= S_UNLINK_WAIT;
          end else begin
            rd_data <= links[walk[IdxW-1:0]];
            state <= S_WALK_WAIT;
          end
        end
        S_WALK_WAIT: begin
          prev <= walk;
          walk <= rd_data;
          steps <= steps + 1'b1;
          state <= S_WALK_RD;
        end
        S_UNLINK_WAIT: begin
          if (prev >= EmptyMark) begin
            heads[cur] <= rd_data;
          end else begin
            links[prev[IdxW-1:0]] <= rd_data;
          end
          if (buddy < addr) begin
            addr <= buddy;
          end
          cur <= cur + 1'b1;
          state <= S_FREE_LVL;
        end
        S_PUSH: begin
          links[addr] <= heads[cur];
          heads[cur] <= {1'b0, addr};
          out <= '{status: StatusDone, granted_index: addr, granted_level: cur};
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("ready while response pending");
  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    cur <= LvlW'(TopLevel)) else $error("level out of range");
  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && out.status == StatusOom |-> out.granted_index == '0)
    else $error("oom with index");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(out)) else $error("rsp lost");
endmodule
`default_nettype wire
